@@ rtl/core/pca_pkg.sv @@
`default_nettype none
package pca_pkg;

	localparam int INDEX_COUNT = 1024;
	localparam int CORE_COUNT  = 4;
	localparam int IDX_W       = $clog2(INDEX_COUNT);
	localparam int LINK_W      = IDX_W + 1;
	localparam int CORE_W      = (CORE_COUNT > 1) ? $clog2(CORE_COUNT) : 1;
	localparam int PART_SIZE   = INDEX_COUNT / CORE_COUNT;
	localparam int PART_W      = $clog2(PART_SIZE);

	// empty-list mark: top bit set, never a valid index
	localparam logic [LINK_W-1:0] NIL = {LINK_W{1'b1}};

	// request kinds
	localparam logic [1:0] REQ_LOCAL  = 2'd0;
	localparam logic [1:0] REQ_GLOBAL = 2'd1;
	localparam logic [1:0] REQ_FREE   = 2'd2;
	// spare kind: changes nothing, answers success with index 0
	localparam logic [1:0] REQ_UNUSED = 2'd3;

	// result codes
	localparam logic [1:0] ST_OK           = 2'd0;
	localparam logic [1:0] ST_EMPTY        = 2'd1;
	localparam logic [1:0] ST_ALREADY_FREE = 2'd2;
	localparam logic [1:0] ST_RANGE        = 2'd3;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [1:0]  core_id;
		logic [9:0]  index;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [9:0]  granted_index;
	} rsp_t;

	// one entry of the link memory
	typedef struct packed {
		logic [LINK_W-1:0] nxt;
		logic              alloc;
		logic [CORE_W-1:0] owner;
	} link_t;

	localparam int LINK_T_W = $bits(link_t);

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_START,
		S_POP_WAIT,
		S_REFILL,
		S_REFILL_WR,
		S_REFILL_END,
		S_GPOP_WAIT,
		S_APPEND,
		S_APPEND_T,
		S_FREE_WAIT,
		S_FREE_P,
		S_RESP
	} state_t;

	function automatic logic link_ok(input logic [LINK_W-1:0] l);
		link_ok = ~l[IDX_W];
	endfunction

endpackage
`default_nettype wire

@@ rtl/core/pca_ram.sv @@
`default_nettype none
module pca_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [WIDTH-1:0]  wdata,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

@@ rtl/core/per_core_index_allocator.sv @@
`default_nettype none
// Per-core index allocator. Indexes are split evenly over the cores; each core has a LIFO
// free list and a doubly linked list of its allocated indexes, and one global free list is
// shared. All links live in two single-port-pair RAMs (next/flags/owner, and previous),
// walked by one small sequencer, so a request is served one at a time. A global allocate
// first refills the global list from every core when it holds no index. After reset the
// block writes the initial chains into the link RAM, one entry for each index, before it
// takes the first request. A finished result waits in an output register, so the next
// request is accepted while it is still stalled.
module per_core_index_allocator (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_stall,
	input  wire pca_pkg::req_t req,
	output logic               rsp_valid,
	input  wire logic          rsp_stall,
	output pca_pkg::rsp_t      rsp
);
	import pca_pkg::*;

	state_t state_q, state_d;

	req_t              req_q;
	logic [IDX_W-1:0]  cnt_q;
	logic [CORE_W-1:0] c_q;
	logic [IDX_W-1:0]  x_q;
	logic [LINK_W-1:0] t_q;
	logic [LINK_W-1:0] n_q;
	logic [LINK_W-1:0] p_q;
	logic [CORE_W-1:0] o_q;
	logic [1:0]        status_q;
	logic [IDX_W-1:0]  grant_q;
	logic [LINK_W-1:0] free_head_q  [CORE_COUNT];
	logic [LINK_W-1:0] alloc_tail_q [CORE_COUNT];
	logic [LINK_W-1:0] gfh_q;
	logic              rsp_valid_q;
	rsp_t              rsp_q;

	logic              m_we, p_we;
	logic [IDX_W-1:0]  m_waddr, m_raddr, p_waddr, p_raddr;
	link_t             m_wdata, m_rdata;
	logic [LINK_W-1:0] p_wdata, p_rdata;

	logic [CORE_W-1:0] core;
	logic              rsp_free;
	logic              last_core;
	logic [LINK_W-1:0] fh_core, fh_c, tail_core;

	assign core      = req_q.core_id[CORE_W-1:0];
	assign rsp_free  = !rsp_valid_q || !rsp_stall;
	assign last_core = (c_q == CORE_W'(CORE_COUNT - 1));
	assign fh_core   = free_head_q[core];
	assign fh_c      = free_head_q[c_q];
	assign tail_core = alloc_tail_q[core];

	pca_ram #(.WIDTH(LINK_T_W), .DEPTH(INDEX_COUNT)) u_link_ram (
		.clk   (clk),
		.we    (m_we),
		.waddr (m_waddr),
		.wdata (m_wdata),
		.raddr (m_raddr),
		.rdata (m_rdata)
	);

	pca_ram #(.WIDTH(LINK_W), .DEPTH(INDEX_COUNT)) u_prev_ram (
		.clk   (clk),
		.we    (p_we),
		.waddr (p_waddr),
		.wdata (p_wdata),
		.raddr (p_raddr),
		.rdata (p_rdata)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR: begin
				if (cnt_q == IDX_W'(INDEX_COUNT - 1)) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (req_valid) state_d = S_START;
			end
			S_START: begin
				case (req_q.req_type)
					REQ_LOCAL:  state_d = link_ok(fh_core) ? S_POP_WAIT : S_RESP;
					REQ_GLOBAL: state_d = link_ok(gfh_q) ? S_GPOP_WAIT : S_REFILL;
					REQ_FREE: begin
						state_d = ({1'b0, req_q.index} < (IDX_W + 1)'(INDEX_COUNT)) ?
							S_FREE_WAIT : S_RESP;
					end
					default:    state_d = S_RESP;
				endcase
			end
			S_POP_WAIT:   state_d = S_APPEND;
			S_REFILL: begin
				if (link_ok(fh_c)) state_d = S_REFILL_WR;
				else if (last_core) state_d = S_REFILL_END;
			end
			S_REFILL_WR:  state_d = last_core ? S_REFILL_END : S_REFILL;
			S_REFILL_END: state_d = link_ok(gfh_q) ? S_GPOP_WAIT : S_RESP;
			S_GPOP_WAIT:  state_d = S_APPEND;
			S_APPEND:     state_d = link_ok(tail_core) ? S_APPEND_T : S_RESP;
			S_APPEND_T:   state_d = S_RESP;
			S_FREE_WAIT: begin
				if (m_rdata.alloc && link_ok(p_rdata)) state_d = S_FREE_P;
				else state_d = S_RESP;
			end
			S_FREE_P:     state_d = S_RESP;
			S_RESP: begin
				if (rsp_free) state_d = S_IDLE;
			end
			default:      state_d = S_IDLE;
		endcase
	end

	// RAM controls
	always_comb begin
		m_we    = 1'b0;
		m_waddr = x_q;
		m_wdata = '{nxt: NIL, alloc: 1'b0, owner: '0};
		m_raddr = x_q;
		p_we    = 1'b0;
		p_waddr = x_q;
		p_wdata = NIL;
		p_raddr = req_q.index;
		case (state_q)
			S_CLEAR: begin
				m_we    = 1'b1;
				m_waddr = cnt_q;
				m_wdata.owner = cnt_q[IDX_W-1 -: CORE_W];
				if (cnt_q[PART_W-1:0] != {PART_W{1'b1}}) begin
					m_wdata.nxt = {1'b0, cnt_q + IDX_W'(1)};
				end
			end
			S_START: begin
				case (req_q.req_type)
					REQ_LOCAL:  m_raddr = fh_core[IDX_W-1:0];
					REQ_GLOBAL: m_raddr = gfh_q[IDX_W-1:0];
					default:    m_raddr = req_q.index;
				endcase
			end
			S_REFILL:     m_raddr = fh_c[IDX_W-1:0];
			S_REFILL_WR: begin
				m_we    = 1'b1;
				m_wdata = '{nxt: gfh_q, alloc: 1'b0, owner: m_rdata.owner};
			end
			S_REFILL_END: m_raddr = gfh_q[IDX_W-1:0];
			S_APPEND: begin
				m_we    = 1'b1;
				m_wdata = '{nxt: NIL, alloc: 1'b1, owner: core};
				p_we    = 1'b1;
				p_wdata = tail_core;
			end
			S_APPEND_T: begin
				m_we    = 1'b1;
				m_waddr = t_q[IDX_W-1:0];
				m_wdata = '{nxt: {1'b0, x_q}, alloc: 1'b1, owner: core};
			end
			S_FREE_WAIT: begin
				if (m_rdata.alloc) begin
					m_we    = 1'b1;
					m_wdata = '{nxt: fh_core, alloc: 1'b0, owner: m_rdata.owner};
					p_we    = link_ok(m_rdata.nxt);
					p_waddr = m_rdata.nxt[IDX_W-1:0];
					p_wdata = p_rdata;
				end
			end
			S_FREE_P: begin
				m_we    = 1'b1;
				m_waddr = p_q[IDX_W-1:0];
				m_wdata = '{nxt: n_q, alloc: 1'b1, owner: o_q};
			end
			default: begin
				m_we = 1'b0;
			end
		endcase
	end

	// sequencer registers and list heads
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			cnt_q   <= '0;
			c_q     <= '0;
			gfh_q   <= NIL;
			for (int c = 0; c < CORE_COUNT; c++) begin
				alloc_tail_q[c] <= NIL;
				free_head_q[c]  <= (c * PART_SIZE < (c + 1) * PART_SIZE) ?
					LINK_W'(c * PART_SIZE) : NIL;
			end
		end else begin
			state_q <= state_d;
			case (state_q)
				S_CLEAR: cnt_q <= cnt_q + IDX_W'(1);
				S_START: begin
					if (req_q.req_type == REQ_GLOBAL) c_q <= '0;
				end
				S_REFILL: begin
					if (!link_ok(fh_c) && !last_core) c_q <= c_q + CORE_W'(1);
				end
				S_REFILL_WR: begin
					free_head_q[c_q] <= m_rdata.nxt;
					gfh_q            <= {1'b0, x_q};
					if (!last_core) c_q <= c_q + CORE_W'(1);
				end
				S_POP_WAIT:  free_head_q[core] <= m_rdata.nxt;
				S_GPOP_WAIT: gfh_q <= m_rdata.nxt;
				S_APPEND:    alloc_tail_q[core] <= {1'b0, x_q};
				S_FREE_WAIT: begin
					if (m_rdata.alloc) begin
						free_head_q[core] <= {1'b0, x_q};
						if (!link_ok(m_rdata.nxt)) alloc_tail_q[m_rdata.owner] <= p_rdata;
					end
				end
				default: begin
					c_q <= c_q;
				end
			endcase
		end
	end

	// request payload and working values
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				req_q    <= req;
				status_q <= ST_OK;
				grant_q  <= '0;
			end
			S_START: begin
				case (req_q.req_type)
					REQ_LOCAL: begin
						x_q <= fh_core[IDX_W-1:0];
						if (!link_ok(fh_core)) status_q <= ST_EMPTY;
					end
					REQ_GLOBAL: x_q <= gfh_q[IDX_W-1:0];
					REQ_FREE: begin
						x_q <= req_q.index;
						if ({1'b0, req_q.index} >= (IDX_W + 1)'(INDEX_COUNT)) begin
							status_q <= ST_RANGE;
						end
					end
					default: x_q <= x_q;
				endcase
			end
			S_REFILL: x_q <= fh_c[IDX_W-1:0];
			S_REFILL_END: begin
				x_q <= gfh_q[IDX_W-1:0];
				if (!link_ok(gfh_q)) status_q <= ST_EMPTY;
			end
			S_APPEND: begin
				t_q     <= tail_core;
				grant_q <= x_q;
			end
			S_FREE_WAIT: begin
				if (!m_rdata.alloc) status_q <= ST_ALREADY_FREE;
				p_q <= p_rdata;
				n_q <= m_rdata.nxt;
				o_q <= m_rdata.owner;
			end
			default: begin
				x_q <= x_q;
			end
		endcase
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (state_q == S_RESP && rsp_free) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_RESP && rsp_free) begin
			rsp_q.status        <= status_q;
			rsp_q.granted_index <= grant_q;
		end
	end

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule
`default_nettype wire

@@ bench/pca_checker.sv @@
`timescale 1ns / 1ps
module pca_checker
	import pca_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	input  wire logic req_stall,
	input  wire req_t req,
	input  wire logic rsp_valid,
	input  wire logic rsp_stall,
	input  wire rsp_t rsp,
	output int        fail_count,
	output int        pending
);

	localparam int NOLINK = -1;

	// shadow copy of the allocator's lists
	int    nxt_link [INDEX_COUNT];
	int    prv_link [INDEX_COUNT];
	bit    taken    [INDEX_COUNT];
	int    owner_of [INDEX_COUNT];
	int    free_top [CORE_COUNT];
	int    used_tail[CORE_COUNT];
	int    pool_top;
	rsp_t  expected_rsps[$];

	function automatic bit is_idx(int x);
		return x >= 0 && x < INDEX_COUNT;
	endfunction

	function automatic int pop_free(int c);
		int x;
		x = free_top[c];
		if (!is_idx(x))
			return NOLINK;
		free_top[c] = nxt_link[x];
		return x;
	endfunction

	function automatic void link_used(int c, int x);
		int t;
		t = used_tail[c];
		nxt_link[x] = NOLINK;
		prv_link[x] = t;
		if (is_idx(t))
			nxt_link[t] = x;
		used_tail[c] = x;
		taken[x] = 1'b1;
		owner_of[x] = c;
	endfunction

	function automatic void clear_lists();
		int lo, hi;
		for (int c = 0; c < CORE_COUNT; c++) begin
			lo = c * INDEX_COUNT / CORE_COUNT;
			hi = (c + 1) * INDEX_COUNT / CORE_COUNT;
			used_tail[c] = NOLINK;
			free_top[c] = (lo < hi) ? lo : NOLINK;
			for (int i = lo; i < hi; i++) begin
				nxt_link[i] = (i + 1 < hi) ? i + 1 : NOLINK;
				prv_link[i] = 0;
				taken[i] = 1'b0;
				owner_of[i] = c;
			end
		end
		pool_top = NOLINK;
	endfunction

	function automatic rsp_t serve_request(req_t r);
		rsp_t o;
		int   c, x, p, n, idx;
		o = '0;
		c = int'(r.core_id) % CORE_COUNT;
		idx = int'(r.index);
		case (r.req_type)
			REQ_LOCAL: begin
				x = pop_free(c);
				if (is_idx(x)) begin
					link_used(c, x);
					o.granted_index = x[9:0];
				end else
					o.status = ST_EMPTY;
			end
			REQ_GLOBAL: begin
				// refill the shared list from every core, core 0 first
				if (!is_idx(pool_top)) begin
					for (int k = 0; k < CORE_COUNT; k++) begin
						x = pop_free(k);
						if (is_idx(x)) begin
							nxt_link[x] = pool_top;
							pool_top = x;
						end
					end
				end
				x = pool_top;
				if (is_idx(x)) begin
					pool_top = nxt_link[x];
					link_used(c, x);
					o.granted_index = x[9:0];
				end else
					o.status = ST_EMPTY;
			end
			REQ_FREE: begin
				if (!is_idx(idx))
					o.status = ST_RANGE;
				else if (!taken[idx])
					o.status = ST_ALREADY_FREE;
				else begin
					p = prv_link[idx];
					n = nxt_link[idx];
					if (is_idx(p))
						nxt_link[p] = n;
					if (is_idx(n))
						prv_link[n] = p;
					else
						used_tail[owner_of[idx]] = p;
					nxt_link[idx] = free_top[c];
					free_top[c] = idx;
					taken[idx] = 1'b0;
				end
			end
			default: ;
		endcase
		return o;
	endfunction

	assign pending = expected_rsps.size();

	initial begin
		fail_count = 0;
		clear_lists();
	end

	// predict on each request transaction, compare on each response transaction
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n) begin
			if (req_valid && !req_stall)
				expected_rsps.push_back(serve_request(req));
			if (rsp_valid && !rsp_stall) begin
				if (expected_rsps.size() == 0) begin
					fail_count++;
					$display("%0t: unexpected response status=%0d index=%0d",
						$time, rsp.status, rsp.granted_index);
				end else begin
					want = expected_rsps.pop_front();
					if (rsp.status !== want.status) begin
						fail_count++;
						$display("%0t: status expected %0d actual %0d",
							$time, want.status, rsp.status);
					end
					if (rsp.granted_index !== want.granted_index) begin
						fail_count++;
						$display("%0t: granted_index expected %0d actual %0d",
							$time, want.granted_index, rsp.granted_index);
					end
				end
			end
		end
	end

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps
module tb;
	import pca_pkg::*;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	req_t req;
	logic rsp_valid;
	logic rsp_stall;
	rsp_t rsp;
	int   fail_count;
	int   pending;

	// indexes this bench believes are allocated, for well-formed frees
	int   held[$];

	per_core_index_allocator u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	pca_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.req        (req),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.rsp        (rsp),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// receiver stall pattern: runs of free flow and runs of random stalls
	initial begin
		int mode, len;
		rsp_stall = 1'b0;
		forever begin
			mode = $urandom_range(0, 2);
			len = $urandom_range(1, 60);
			repeat (len) begin
				@(posedge clk);
				rsp_stall <= (mode == 0) ? 1'b0 : ($urandom_range(0, 3) < mode);
			end
		end
	end

	// track granted indexes so frees can target live ones
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall && rsp.status == ST_OK &&
			rsp.granted_index != 0)
			held.push_back(int'(rsp.granted_index));
	end

	// hold one request until the allocator takes it
	task automatic send_request(logic [1:0] kind, logic [1:0] core, logic [9:0] idx);
		req_valid <= 1'b1;
		req <= '{req_type: kind, core_id: core, index: idx};
		do @(posedge clk); while (req_stall);
	endtask

	task automatic pause_sender();
		req_valid <= 1'b0;
		repeat ($urandom_range(1, 8)) @(posedge clk);
	endtask

	task automatic drain_responses();
		req_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (40) @(posedge clk);
	endtask

	function automatic logic [9:0] pick_free_target();
		int k;
		if (held.size() == 0 || $urandom_range(0, 9) == 0)
			return 10'($urandom);
		k = $urandom_range(0, held.size() - 1);
		pick_free_target = 10'(held[k]);
		held.delete(k);
	endfunction

	initial begin
		int burst, pick;
		logic [1:0] kind;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: every request kind, every core, field extremes
		send_request(REQ_FREE, 2'd0, 10'd0);
		send_request(REQ_FREE, 2'd3, 10'h3FF);
		for (int c = 0; c < 4; c++)
			send_request(REQ_LOCAL, 2'(c), 10'h3FF);
		send_request(REQ_FREE, 2'd0, 10'd0);
		send_request(REQ_FREE, 2'd1, 10'd256);
		send_request(REQ_FREE, 2'd3, 10'd1);
		send_request(REQ_GLOBAL, 2'd2, 10'd0);
		send_request(REQ_GLOBAL, 2'd3, 10'h2AA);
		send_request(REQ_UNUSED, 2'd1, 10'h155);
		send_request(REQ_FREE, 2'd2, 10'd512);
		send_request(REQ_LOCAL, 2'd2, 10'd0);
		drain_responses();

		// empty one core's free list, then ask once more
		repeat (260) send_request(REQ_LOCAL, 2'd1, 10'($urandom));
		drain_responses();
		send_request(REQ_GLOBAL, 2'd1, 10'd0);

		// random bursts, mostly well-formed allocate/free mixes
		for (int n = 0; n < 1720; ) begin
			burst = $urandom_range(1, 30);
			repeat (burst) begin
				pick = $urandom_range(0, 99);
				if (pick < 35) kind = REQ_LOCAL;
				else if (pick < 55) kind = REQ_GLOBAL;
				else if (pick < 97) kind = REQ_FREE;
				else kind = REQ_UNUSED;
				send_request(kind, 2'($urandom),
					(kind == REQ_FREE) ? pick_free_target() : 10'($urandom));
				n++;
			end
			if ($urandom_range(0, 3) == 0)
				pause_sender();
			if (n > 1000 && n < 1040)
				drain_responses();
		end

		drain_responses();
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		#20ms;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
